>>> design/irw_pkg.sv
// Shared types, constants and the root table for the radial warp block.
package irw_pkg;

    localparam int DEF_MAX_WIDTH        = 512;
    localparam int DEF_MAX_HEIGHT       = 512;
    localparam int DEF_AMOUNT_FRAC_BITS = 12;

    localparam int POS_W   = 9;   // pos_x / pos_y
    localparam int PIX_W   = 32;  // ARGB word
    localparam int FRAME_W = 10;  // frame_width / frame_height registers
    localparam int AMT_W   = 16;  // amount register
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIM_W  = 13;   // clamped width/height, centre, sample coordinate
    localparam int DIFF_W = 14;   // signed distance from centre
    localparam int SQ_W   = 21;   // squared distances
    localparam int LOG_W  = 21;   // log2 in Q5.16
    localparam int FRAC_W = 16;
    localparam int M_W    = 32;   // log mantissa, Q1.30 plus headroom
    localparam int P_W    = 31;   // exp product, Q0.30 up to 1.0
    localparam int FAC_W  = 17;   // factor, Q1.16
    localparam int PROD_W = LOG_W + AMT_W;
    localparam int S_W    = 34;   // sample sum before the 16-bit shift
    localparam int ROOT_N = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_AMOUNT       = 2'd2
    } cfg_idx_t;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    typedef struct packed {
        logic capture;
        logic store_wr;
        logic geom;
        logic range;
        logic fac_one;
        logic fac_zero;
        logic log_load;
        logic log_sel;     // 0 radius squared, 1 distance squared
        logic log_norm;
        logic log_sq;
        logic log_latch;
        logic mul_e;
        logic exp_step;
        logic fact;
        logic samp_x;
        logic samp_y;
        logic mem_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic oob;
        logic pass;
        logic amt_zero;
        logic d2_zero;
        logic norm_done;
        logic step_last;
    } sts_t;

    typedef logic [P_W-1:0] root_tab_t [ROOT_N];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bt;
        res = '0;
        rem = v;
        bt  = 64'h1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bt) begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // T[k] = 2^(-2^-k) in Q0.30, by repeated square roots from 0.5
    function automatic root_tab_t calc_root_tab();
        root_tab_t   t;
        logic [63:0] cur;
        cur  = 64'h1 << 29;
        t[0] = P_W'(cur);
        for (int k = 1; k < ROOT_N; k++) begin
            cur  = isqrt64(cur << 30);
            t[k] = P_W'(cur);
        end
        return t;
    endfunction

    localparam root_tab_t ROOT_TAB = calc_root_tab();

endpackage

>>> design/irw_ctrl.sv
// Sequencer for the radial warp: handshakes, step order and the output valid flag.
module irw_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_kind,
    output logic          m_tvalid,
    input  logic          m_tready,
    output irw_pkg::cmd_t cmd,
    input  irw_pkg::sts_t sts
);
    import irw_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_GEOM     = 15'h0002,
        S_RANGE    = 15'h0004,
        S_DECIDE   = 15'h0008,
        S_LOG_LOAD = 15'h0010,
        S_LOG_NORM = 15'h0020,
        S_LOG_SQ   = 15'h0040,
        S_LOG_END  = 15'h0080,
        S_MUL_E    = 15'h0100,
        S_EXP      = 15'h0200,
        S_FACT     = 15'h0400,
        S_SX       = 15'h0800,
        S_SY       = 15'h1000,
        S_RD       = 15'h2000,
        S_WB       = 15'h4000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;
    logic   valid_reg, valid_next;
    logic   out_busy;

    assign out_busy = valid_reg & ~m_tready;
    assign m_tvalid = valid_reg;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.log_sel = sel_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (s_kind == KIND_LOAD) begin
                        cmd.store_wr = 1'b1;
                    end else begin
                        state_next = S_GEOM;
                    end
                end
            end
            S_GEOM: begin
                cmd.geom   = 1'b1;
                state_next = S_RANGE;
            end
            S_RANGE: begin
                cmd.range  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (sts.oob) begin
                    state_next = S_WB;
                end else if (sts.pass) begin
                    state_next = S_RD;
                end else if (sts.amt_zero) begin
                    cmd.fac_one = 1'b1;
                    state_next  = S_SX;
                end else if (sts.d2_zero) begin
                    cmd.fac_zero = 1'b1;
                    state_next   = S_SX;
                end else begin
                    sel_next   = 1'b0;
                    state_next = S_LOG_LOAD;
                end
            end
            S_LOG_LOAD: begin
                cmd.log_load = 1'b1;
                state_next   = S_LOG_NORM;
            end
            S_LOG_NORM: begin
                if (sts.norm_done) begin
                    state_next = S_LOG_SQ;
                end else begin
                    cmd.log_norm = 1'b1;
                end
            end
            S_LOG_SQ: begin
                cmd.log_sq = 1'b1;
                if (sts.step_last) begin
                    state_next = S_LOG_END;
                end
            end
            S_LOG_END: begin
                cmd.log_latch = 1'b1;
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = S_LOG_LOAD;
                end else begin
                    state_next = S_MUL_E;
                end
            end
            S_MUL_E: begin
                cmd.mul_e  = 1'b1;
                state_next = S_EXP;
            end
            S_EXP: begin
                cmd.exp_step = 1'b1;
                if (sts.step_last) begin
                    state_next = S_FACT;
                end
            end
            S_FACT: begin
                cmd.fact   = 1'b1;
                state_next = S_SX;
            end
            S_SX: begin
                cmd.samp_x = 1'b1;
                state_next = S_SY;
            end
            S_SY: begin
                cmd.samp_y = 1'b1;
                state_next = S_RD;
            end
            S_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_WB;
            end
            S_WB: begin
                if (!out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

endmodule

>>> design/irw_dp.sv
// Datapath for the radial warp: frame store, geometry, log/exp units and sampling.
module irw_dp #(
    parameter int MAX_WIDTH        = irw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT       = irw_pkg::DEF_MAX_HEIGHT,
    parameter int AMOUNT_FRAC_BITS = irw_pkg::DEF_AMOUNT_FRAC_BITS
) (
    input  logic                        aclk,
    input  irw_pkg::cmd_t               cmd,
    output irw_pkg::sts_t               sts,
    input  logic [irw_pkg::POS_W-1:0]   in_pos_x,
    input  logic [irw_pkg::POS_W-1:0]   in_pos_y,
    input  logic [irw_pkg::PIX_W-1:0]   in_pixel,
    input  logic [irw_pkg::FRAME_W-1:0] frame_width,
    input  logic [irw_pkg::FRAME_W-1:0] frame_height,
    input  logic [irw_pkg::AMT_W-1:0]   amount,
    output logic [irw_pkg::PIX_W-1:0]   pixel_out,
    output logic                        inside_radius
);
    import irw_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int V_W    = S_W - 16;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_q;

    logic [POS_W-1:0]         x_reg, y_reg;
    logic [DIM_W-1:0]         w_reg, h_reg, xc_reg, yc_reg, r_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic                     oob_reg;
    logic [SQ_W-1:0]          d2_reg, r2_reg;
    logic [M_W-1:0]           lm_reg;
    logic [4:0]               le_reg;
    logic [FRAC_W-1:0]        lf_reg;
    logic [3:0]               cnt_reg;
    logic [LOG_W-1:0]         lr_reg, n_reg;
    logic [PROD_W-1:0]        e_reg;
    logic [P_W-1:0]           p_reg;
    logic [FAC_W-1:0]         fac_reg;
    logic [DIM_W-1:0]         sx_reg, sy_reg;

    // geometry
    logic [DIM_W-1:0] w_c, h_c, xc_c, yc_c;
    always_comb begin
        w_c = DIM_W'(frame_width);
        if (w_c == '0) begin
            w_c = DIM_W'(1);
        end else if (w_c > DIM_W'(MAX_WIDTH)) begin
            w_c = DIM_W'(MAX_WIDTH);
        end
        h_c = DIM_W'(frame_height);
        if (h_c == '0) begin
            h_c = DIM_W'(1);
        end else if (h_c > DIM_W'(MAX_HEIGHT)) begin
            h_c = DIM_W'(MAX_HEIGHT);
        end
        xc_c = w_c >> 1;
        yc_c = h_c >> 1;
    end

    logic signed [2*DIFF_W-1:0] sqx, sqy;
    logic [2*DIM_W-1:0]         sqr;
    assign sqx = dx_reg * dx_reg;
    assign sqy = dy_reg * dy_reg;
    assign sqr = r_reg * r_reg;

    // log2: mantissa squaring
    logic [2*M_W-1:0] lsq;
    logic [M_W-1:0]   lsq_s;
    assign lsq   = lm_reg * lm_reg;
    assign lsq_s = lsq[M_W+29:30];

    logic [LOG_W-1:0] log_val;
    assign log_val = {le_reg, lf_reg};

    logic [PROD_W-1:0] ne_prod;
    assign ne_prod = n_reg * amount;

    // exp2 of the negative exponent, one fraction bit a step
    logic [FRAC_W-1:0] e_frac;
    logic [4:0]        tab_idx;
    logic [2*P_W-1:0]  pt;
    assign e_frac  = e_reg[FRAC_W-1:0];
    assign tab_idx = {1'b0, cnt_reg} + 5'd1;
    assign pt      = p_reg * ROOT_TAB[tab_idx];

    logic [PROD_W-FRAC_W-1:0] e_ip;
    logic [4:0]               fshift;
    assign e_ip   = e_reg[PROD_W-1:FRAC_W];
    assign fshift = 5'd14 + e_ip[4:0];

    // sample coordinate, shared between x and y
    logic signed [DIFF_W-1:0] s_diff;
    logic [DIM_W-1:0]         s_c, s_lim;
    logic signed [S_W-1:0]    s_mul, s_sum;
    logic [V_W-1:0]           s_v;
    logic [DIM_W-1:0]         s_coord;
    always_comb begin
        s_diff = cmd.samp_y ? dy_reg : dx_reg;
        s_c    = cmd.samp_y ? yc_reg : xc_reg;
        s_lim  = cmd.samp_y ? h_reg  : w_reg;
        s_mul  = $signed({1'b0, fac_reg}) * s_diff;
        s_sum  = s_mul + $signed(S_W'({s_c, 16'h0}));
        s_v    = s_sum[S_W-1] ? '0 : V_W'(s_sum[S_W-1:16]);
        if (s_v > V_W'(s_lim - DIM_W'(1))) begin
            s_coord = s_lim - DIM_W'(1);
        end else begin
            s_coord = DIM_W'(s_v);
        end
    end

    logic inside_c;
    assign inside_c = ~oob_reg & (d2_reg < r2_reg);

    logic [ADDR_W-1:0] waddr, raddr;
    logic              w_in_store;
    assign waddr = ADDR_W'(in_pos_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_pos_x);
    assign w_in_store = (DIM_W'(in_pos_x) < DIM_W'(MAX_WIDTH))
                      & (DIM_W'(in_pos_y) < DIM_W'(MAX_HEIGHT));
    assign raddr = inside_c
                 ? ADDR_W'(sy_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx_reg)
                 : ADDR_W'(y_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_reg);

    always_ff @(posedge aclk) begin
        if (cmd.store_wr && w_in_store) begin
            mem[waddr] <= in_pixel;
        end
        if (cmd.mem_rd) begin
            rd_q <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg <= in_pos_x;
            y_reg <= in_pos_y;
        end
        if (cmd.geom) begin
            w_reg   <= w_c;
            h_reg   <= h_c;
            xc_reg  <= xc_c;
            yc_reg  <= yc_c;
            r_reg   <= (xc_c < yc_c) ? xc_c : yc_c;
            dx_reg  <= $signed(DIFF_W'(x_reg)) - $signed(DIFF_W'(xc_c));
            dy_reg  <= $signed(DIFF_W'(y_reg)) - $signed(DIFF_W'(yc_c));
            oob_reg <= (DIM_W'(x_reg) >= DIM_W'(MAX_WIDTH))
                     | (DIM_W'(y_reg) >= DIM_W'(MAX_HEIGHT));
        end
        if (cmd.range) begin
            d2_reg <= SQ_W'($unsigned(sqx)) + SQ_W'($unsigned(sqy));
            r2_reg <= SQ_W'(sqr);
        end
        if (cmd.log_load) begin
            lm_reg <= M_W'(cmd.log_sel ? d2_reg : r2_reg);
            le_reg <= 5'd30;
            lf_reg <= '0;
        end else if (cmd.log_norm) begin
            lm_reg <= lm_reg << 1;
            le_reg <= le_reg - 5'd1;
        end else if (cmd.log_sq) begin
            if (lsq_s[M_W-1]) begin
                lm_reg <= lsq_s >> 1;
                lf_reg <= {lf_reg[FRAC_W-2:0], 1'b1};
            end else begin
                lm_reg <= lsq_s;
                lf_reg <= {lf_reg[FRAC_W-2:0], 1'b0};
            end
        end
        if (cmd.log_load || cmd.mul_e) begin
            cnt_reg <= '0;
        end else if (cmd.log_sq || cmd.exp_step) begin
            cnt_reg <= cnt_reg + 4'd1;
        end
        if (cmd.log_latch) begin
            if (!cmd.log_sel) begin
                lr_reg <= log_val;
            end else begin
                n_reg <= lr_reg - log_val;
            end
        end
        if (cmd.mul_e) begin
            e_reg <= ne_prod >> (AMOUNT_FRAC_BITS + 1);
            p_reg <= P_W'(1) << 30;
        end else if (cmd.exp_step && e_frac[4'd15 - cnt_reg]) begin
            p_reg <= pt[P_W+29:30];
        end
        if (cmd.fac_one) begin
            fac_reg <= FAC_W'(1) << 16;
        end else if (cmd.fac_zero) begin
            fac_reg <= '0;
        end else if (cmd.fact) begin
            if (e_ip >= (PROD_W-FRAC_W)'(17)) begin
                fac_reg <= '0;
            end else begin
                fac_reg <= FAC_W'(p_reg >> fshift);
            end
        end
        if (cmd.samp_x) begin
            sx_reg <= s_coord;
        end
        if (cmd.samp_y) begin
            sy_reg <= s_coord;
        end
        if (cmd.out_load) begin
            pixel_out     <= oob_reg ? '0 : rd_q;
            inside_radius <= inside_c;
        end
    end

    assign sts.oob       = oob_reg;
    assign sts.pass      = d2_reg >= r2_reg;
    assign sts.amt_zero  = (amount == '0);
    assign sts.d2_zero   = (d2_reg == '0);
    assign sts.norm_done = lm_reg[30];
    assign sts.step_last = (cnt_reg == 4'd15);

endmodule

>>> design/implode_radial_warp.sv
// Top level of the radial warp block: configuration registers, sequencer and datapath.
//
// A load request (tuser 0) writes one ARGB word into the frame store at (pos_x, pos_y); the
// block is ready again in the next cycle. A compute request (tuser 1) returns one output
// pixel. The sequencer runs one compute at a time, and its length is set by the shared log2
// unit (a one-bit-a-cycle normalising shift, then sixteen mantissa squarings through one
// 32x32 multiplier, run once for r^2 and once for d^2) and by the sixteen-step exp2 product
// loop. A pixel at or outside the radius, a pixel inside with amount zero or at the centre,
// and a position beyond the store skip the log2 and exp2 loops; only a warped pixel runs
// them. The frame store has one write and one registered read port; its content is
// undefined until written, so read only pixels that were loaded. The result sits in an
// output register, and the next request is taken while it waits for m_tready.
module implode_radial_warp #(
    parameter int MAX_WIDTH        = irw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT       = irw_pkg::DEF_MAX_HEIGHT,
    parameter int AMOUNT_FRAC_BITS = irw_pkg::DEF_AMOUNT_FRAC_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [55:0]                    s_tdata,   // pos_x[8:0], pos_y[17:9], pixel_in[49:18]
    input  logic                           s_tuser,   // kind
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [irw_pkg::PIX_W-1:0]      m_tdata,   // pixel_out[31:0]
    output logic                           m_tuser,   // inside_radius
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [irw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import irw_pkg::*;

    logic [FRAME_W-1:0] width_reg, height_reg;
    logic [AMT_W-1:0]   amount_reg;
    cmd_t               cmd;
    sts_t               sts;

    // Configuration is always accepted; writes beyond the register list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= FRAME_W'(512);
            height_reg <= FRAME_W'(512);
            amount_reg <= AMT_W'(4096);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[FRAME_W-1:0];
                CFG_AMOUNT:       amount_reg <= cfg_data[AMT_W-1:0];
                default: ;
            endcase
        end
    end

    irw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    irw_dp #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_HEIGHT       (MAX_HEIGHT),
        .AMOUNT_FRAC_BITS (AMOUNT_FRAC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .cmd           (cmd),
        .sts           (sts),
        .in_pos_x      (s_tdata[8:0]),
        .in_pos_y      (s_tdata[17:9]),
        .in_pixel      (s_tdata[49:18]),
        .frame_width   (width_reg),
        .frame_height  (height_reg),
        .amount        (amount_reg),
        .pixel_out     (m_tdata),
        .inside_radius (m_tuser)
    );

    // Hold a finished result until the output register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_tvalid && !m_tready))
        else $error("result loaded over a pending result");

    // Write the store only for an accepted load request.
    a_store_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_wr |-> (s_tvalid && s_tready && s_tuser == KIND_LOAD))
        else $error("store written without a load request");

    // Drop ready once a compute request enters.
    a_busy_after_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_COMPUTE) |=> !s_tready)
        else $error("ready held after compute request");

endmodule

>>> tb/irw_checker.sv
// Predictor and scoreboard for the radial warp block: watches all three channels.
`timescale 1ns / 1ps

module irw_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);
    import irw_pkg::*;

    typedef struct {
        logic [31:0] pixel;
        logic        in_radius;
    } warp_res_t;

    logic [9:0]      width_q  = 10'd512;
    logic [9:0]      height_q = 10'd512;
    logic [15:0]     amount_q = 16'd4096;
    logic [31:0]     pix_mem [int];
    longint unsigned root_q [17];
    warp_res_t       warp_q [$];

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bt = 64'h1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned log2_fix(longint unsigned v);
        int              e = 63;
        longint unsigned m;
        longint unsigned res;
        while (e > 0 && v[e] == 1'b0) e--;
        m   = (e > 30) ? (v >> (e - 30)) : (v << (30 - e));
        res = longint'(e) << 16;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'h1 << 31)) begin
                m >>= 1;
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic longint unsigned exp2_neg(longint unsigned e);
        longint unsigned ip = e >> 16;
        longint unsigned p = 64'h1 << 30;
        if (ip >= 17) return 0;
        for (int k = 1; k <= 16; k++)
            if (e[16-k]) p = (p * root_q[k]) >> 30;
        return p >> (14 + ip);
    endfunction

    function automatic int warp_coord(longint factor, int diff, int c, int lim);
        longint s;
        longint v;
        s = factor * longint'(diff) + longint'(c) * 65536;
        v = (s < 0) ? 0 : s / 65536;
        if (v > lim - 1) v = lim - 1;
        return int'(v);
    endfunction

    function automatic logic [31:0] mem_read(int x, int y);
        int a = y * 512 + x;
        return pix_mem.exists(a) ? pix_mem[a] : 32'h0;
    endfunction

    function automatic warp_res_t predict_warp(int x, int y);
        warp_res_t       r;
        int              w, h, xc, yc, rad, dx, dy;
        longint          d2, r2, factor;
        longint unsigned n, e;
        w  = (width_q == 0) ? 1 : (width_q > 512) ? 512 : int'(width_q);
        h  = (height_q == 0) ? 1 : (height_q > 512) ? 512 : int'(height_q);
        xc = w >> 1;
        yc = h >> 1;
        rad = (xc < yc) ? xc : yc;
        dx = x - xc;
        dy = y - yc;
        d2 = longint'(dx) * dx + longint'(dy) * dy;
        r2 = longint'(rad) * rad;
        if (d2 >= r2) begin
            r.pixel     = mem_read(x, y);
            r.in_radius = 1'b0;
        end else begin
            if (amount_q == 0) factor = 65536;
            else if (d2 == 0) factor = 0;
            else begin
                n = log2_fix(r2) - log2_fix(d2);
                e = (n * amount_q) >> 13;
                factor = longint'(exp2_neg(e));
            end
            r.pixel     = mem_read(warp_coord(factor, dx, xc, w), warp_coord(factor, dy, yc, h));
            r.in_radius = 1'b1;
        end
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t irw_checker: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    initial begin
        errors  = 0;
        pending = 0;
        root_q[0] = 64'h1 << 29;
        for (int k = 1; k < 17; k++) root_q[k] = int_root(root_q[k-1] << 30);
    end

    always @(posedge aclk) begin
        warp_res_t want;
        if (aresetn) begin
            // compare before predicting: a result never belongs to a request of the same edge
            if (m_tvalid && m_tready) begin
                if (warp_q.size() == 0) begin
                    report("result with nothing outstanding", m_tdata, 32'h0);
                end else begin
                    want = warp_q.pop_front();
                    if (m_tdata !== want.pixel) report("pixel_out", m_tdata, want.pixel);
                    if (m_tuser !== want.in_radius)
                        report("inside_radius", m_tuser, want.in_radius);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FRAME_WIDTH:  width_q  = cfg_data[9:0];
                    CFG_FRAME_HEIGHT: height_q = cfg_data[9:0];
                    CFG_AMOUNT:       amount_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_LOAD)
                    pix_mem[int'(s_tdata[17:9]) * 512 + int'(s_tdata[8:0])] = s_tdata[49:18];
                else
                    warp_q.push_back(predict_warp(int'(s_tdata[8:0]), int'(s_tdata[17:9])));
            end
            pending = warp_q.size();
        end
    end
endmodule

>>> tb/implode_radial_warp_tb.sv
// Stimulus and verdict for the radial warp block; checking lives in irw_checker.
`timescale 1ns / 1ps

module implode_radial_warp_tb;
    import irw_pkg::*;

    localparam int LIMIT = 1_000_000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // pos_x[8:0], pos_y[17:9], pixel_in[49:18]
    logic        s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // pixel_out[31:0]
    logic        m_tuser;   // inside_radius
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;

    // stimulus-side view of the store and the active settings, used to keep every read legal
    bit          written [0:262143];
    int          wr_list [$];
    int          cur_w, cur_h, cur_amt;
    bit          frame_full;
    int          idle_pct;
    int          stall_pct;
    bit          pressure;
    bit          held;
    int          cycles;

    implode_radial_warp dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    irw_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Guard against a hung block: count every cycle and give up well past the slowest run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("implode_radial_warp_tb: FAIL");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off in the pressure phase so the
    // output register fills and the block stalls its input.
    initial begin
        m_tready = 1'b0;
        held     = 1'b0;
        forever begin
            @(posedge aclk);
            if (pressure && !held) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                held = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one request and hold it until taken, then perhaps idle the sender for a while.
    task automatic send(logic kind, int x, int y, logic [31:0] pix);
        s_tdata  <= {6'b0, pix, 9'(y), 9'(x)};
        s_tuser  <= kind;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic load(int x, int y, logic [31:0] pix);
        int a = y * 512 + x;
        if (!written[a]) wr_list.push_back(a);
        written[a] = 1'b1;
        send(KIND_LOAD, x, y, pix);
    endtask

    // Only compute where every pixel it could read has been loaded.
    function automatic bit safe_read(int x, int y);
        int xc = cur_w >> 1;
        int yc = cur_h >> 1;
        int r  = (xc < yc) ? xc : yc;
        bit in_rad;
        if (!written[y * 512 + x]) return 1'b0;
        in_rad = (x - xc) * (x - xc) + (y - yc) * (y - yc) < r * r;
        return !(in_rad && cur_amt != 0 && !frame_full);
    endfunction

    task automatic compute(int x, int y);
        if (safe_read(x, y)) send(KIND_COMPUTE, x, y, $urandom);
    endtask

    // Drain outstanding results and let a trailing load or compute settle.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (150) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic run_phase(int wr, int hr, int amt, int idle, int stall, int n, bit press);
        int x, y, xc, yc, a;
        settle();
        cfg_write(CFG_FRAME_WIDTH, 16'(wr));
        cfg_write(CFG_FRAME_HEIGHT, 16'(hr));
        cfg_write(CFG_AMOUNT, 16'(amt));
        cfg_valid <= 1'b0;
        idle_pct  = idle;
        stall_pct = stall;
        cur_w   = ((wr & 1023) == 0) ? 1 : ((wr & 1023) > 512) ? 512 : (wr & 1023);
        cur_h   = ((hr & 1023) == 0) ? 1 : ((hr & 1023) > 512) ? 512 : (hr & 1023);
        cur_amt = amt;
        xc = cur_w >> 1;
        yc = cur_h >> 1;
        // load the whole active frame when small, so warped samples always land on data
        frame_full = (cur_w * cur_h <= 200);
        if (frame_full)
            for (y = 0; y < cur_h; y++)
                for (x = 0; x < cur_w; x++) load(x, y, $urandom);
        // directed corners, centre, extreme pixel values and the far corner of the store
        load(0, 0, 32'hFFFF_FFFF);
        load(cur_w - 1, cur_h - 1, 32'h0000_0000);
        load(511, 511, $urandom);
        compute(xc, yc);
        compute((xc + 1) % cur_w, yc);
        compute(xc, (yc > 0) ? yc - 1 : 0);
        compute(0, 0);
        compute(cur_w - 1, cur_h - 1);
        compute(511, 511);
        if (press) pressure <= 1'b1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 35) begin
                if ($urandom_range(99) < 70)
                    load($urandom_range(cur_w - 1), $urandom_range(cur_h - 1), $urandom);
                else
                    load($urandom_range(511), $urandom_range(511), $urandom);
            end else begin
                if ($urandom_range(1)) begin
                    x = $urandom_range(cur_w - 1);
                    y = $urandom_range(cur_h - 1);
                end else begin
                    a = wr_list[$urandom_range(wr_list.size() - 1)];
                    x = a % 512;
                    y = a / 512;
                end
                if (safe_read(x, y)) send(KIND_COMPUTE, x, y, $urandom);
                else load(x, y, $urandom);
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_LOAD;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data  = '0;
        idle_pct  = 0;
        stall_pct = 0;
        pressure  = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_phase(12,   10,   4096,  0,  0,  60, 1'b0);
        run_phase(9,    14,   65535, 79, 0,  60, 1'b0);
        run_phase(0,    1023, 0,     0,  79, 40, 1'b0);  // width used as 1: zero radius
        run_phase(1023, 1023, 0,     0,  79, 60, 1'b0);  // full frame, unit factor
        run_phase(7,    5,    1,     6,  6,  60, 1'b0);
        run_phase(16,   8,    2048,  0,  0,  80, 1'b1);  // long receiver hold-off
        run_phase(2,    2,    40000, 0,  79, 40, 1'b0);
        run_phase(512,  1,    12345, 79, 79, 40, 1'b0);  // zero radius, wide frame

        settle();
        if (errors == 0) begin
            $display("implode_radial_warp_tb: PASS");
        end else begin
            $display("implode_radial_warp_tb: FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/irw_pkg.sv
design/irw_ctrl.sv
design/irw_dp.sv
design/implode_radial_warp.sv
tb/irw_checker.sv
tb/implode_radial_warp_tb.sv
